@@ rtl/bod_pkg.sv @@
// Package for the box overlap dedup unit: sizes, config codes, sequencer states.
package bod_pkg;

  localparam int unsigned KeepMax = 64;
  localparam int unsigned AddrW   = $clog2(KeepMax);
  localparam int unsigned CntW    = $clog2(KeepMax + 1);
  localparam int unsigned BoxW    = 64;

  localparam logic [3:0] NumReset = 4'd7;
  localparam logic [3:0] DenReset = 4'd10;

  localparam logic CfgNum = 1'b0;
  localparam logic CfgDen = 1'b1;

  typedef enum logic [2:0] {
    SIdle,
    SArea,
    SGeo,
    SMulI,
    SMulB,
    SUni,
    SCmp,
    SOut
  } state_e;

  typedef struct packed {
    logic [15:0] h;
    logic [15:0] w;
    logic [15:0] y;
    logic [15:0] x;
  } box_t;

endpackage

@@ rtl/bod_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
module bod_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 64,
  parameter int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/box_overlap_dedup_unit.sv @@
// Box overlap dedup: IoU non-maximum suppression against the boxes kept in the frame.
// Sequence: SArea, then SGeo, SMulI, SMulB, SUni and SCmp for each of k kept boxes
// compared (stops early at the first duplicate, at most KeepMax), then SOut; busy until the result.
// For each kept box the shared 16x16 multiplier is used twice.
// Reset: kept count cleared, thresholds 7/10, table contents undefined until written.
// Results are strobed for one cycle; the receiver cannot stall.
module box_overlap_dedup_unit
  import bod_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [15:0] box_x_i,
  input  logic [15:0] box_y_i,
  input  logic [15:0] box_w_i,
  input  logic [15:0] box_h_i,
  input  logic        frame_last_i,
  output logic        valid_o,
  output logic        keep_o,
  output logic        table_full_o,
  output logic        frame_end_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [3:0]  cfg_data_i
);

  state_e state_q, state_d;

  logic [3:0]      num_q, den_q;
  logic [CntW-1:0] count_q, count_d;
  logic [CntW-1:0] idx_q, idx_d;
  box_t            cur_q;
  logic            last_q;
  logic            keep_q, keep_d;

  logic [31:0] areaa_q, areaa_d;
  logic [31:0] inter_q, inter_d;
  logic [31:0] areab_q, areab_d;
  logic [32:0] uni_q, uni_d;
  logic [15:0] inw_q, inw_d, inh_q, inh_d;
  logic [15:0] bw_q, bw_d, bh_q, bh_d;
  logic        contain_q, contain_d;

  logic        valid_q, valid_d;
  logic        okeep_q, okeep_d, ofull_q, ofull_d, oend_q, oend_d;

  logic             rd_en;
  logic [AddrW-1:0] rd_addr;
  logic             wr_en;
  logic [BoxW-1:0]  rdata;
  box_t             b;

  logic [15:0] mul_a, mul_b;
  logic [31:0] prod;

  logic [15:0] lx, ty;
  logic [16:0] ra, rb, ba, bb, rx, by;
  logic        ovl;
  box_t        inb;

  logic [35:0] lhs;
  logic [36:0] rhs;
  logic        dup;
  logic        accept;
  logic        full;

  assign accept      = start && !busy;
  assign busy        = (state_q != SIdle);
  assign cfg_ready_o = 1'b1;

  bod_ram #(
    .Width(BoxW),
    .Depth(KeepMax)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (count_q[AddrW-1:0]),
    .wdata_i (cur_q),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rdata)
  );

  assign b = box_t'(rdata);

  // shared multiplier
  always_comb begin
    mul_a = cur_q.w;
    mul_b = cur_q.h;
    if (state_q == SMulI) begin
      mul_a = inw_q;
      mul_b = inh_q;
    end else if (state_q == SMulB) begin
      mul_a = bw_q;
      mul_b = bh_q;
    end
  end
  assign prod = mul_a * mul_b;

  // intersection geometry
  always_comb begin
    lx  = (cur_q.x > b.x) ? cur_q.x : b.x;
    ty  = (cur_q.y > b.y) ? cur_q.y : b.y;
    ra  = {1'b0, cur_q.x} + {1'b0, cur_q.w};
    rb  = {1'b0, b.x} + {1'b0, b.w};
    ba  = {1'b0, cur_q.y} + {1'b0, cur_q.h};
    bb  = {1'b0, b.y} + {1'b0, b.h};
    rx  = (ra < rb) ? ra : rb;
    by  = (ba < bb) ? ba : bb;
    ovl = (rx > {1'b0, lx}) && (by > {1'b0, ty});
    inb = '0;
    if (ovl) begin
      inb.x = lx;
      inb.y = ty;
      inb.w = 16'(rx - {1'b0, lx});
      inb.h = 16'(by - {1'b0, ty});
    end
  end

  assign lhs  = 36'(inter_q) * 36'(den_q);
  assign rhs  = 37'(uni_q) * 37'(num_q);
  assign dup  = contain_q || (37'(lhs) > rhs);
  assign full = (count_q == CntW'(KeepMax));

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    idx_d     = idx_q;
    keep_d    = keep_q;
    areaa_d   = areaa_q;
    inter_d   = inter_q;
    areab_d   = areab_q;
    uni_d     = uni_q;
    inw_d     = inw_q;
    inh_d     = inh_q;
    bw_d      = bw_q;
    bh_d      = bh_q;
    contain_d = contain_q;
    valid_d   = 1'b0;
    okeep_d   = okeep_q;
    ofull_d   = ofull_q;
    oend_d    = oend_q;
    rd_en     = 1'b0;
    rd_addr   = '0;
    wr_en     = 1'b0;
    unique case (state_q)
      SIdle: begin
        if (start) begin
          keep_d  = 1'b1;
          state_d = SArea;
        end
      end
      SArea: begin
        areaa_d = prod;
        idx_d   = '0;
        if (count_q == '0) begin
          state_d = SOut;
        end else begin
          rd_en   = 1'b1;
          state_d = SGeo;
        end
      end
      SGeo: begin
        inw_d     = inb.w;
        inh_d     = inb.h;
        bw_d      = b.w;
        bh_d      = b.h;
        contain_d = (inb == cur_q) || (inb == b);
        state_d   = SMulI;
      end
      SMulI: begin
        inter_d = prod;
        state_d = SMulB;
      end
      SMulB: begin
        areab_d = prod;
        state_d = SUni;
      end
      SUni: begin
        uni_d   = 33'(areaa_q) + 33'(areab_q) - 33'(inter_q);
        state_d = SCmp;
      end
      SCmp: begin
        if (dup) begin
          keep_d  = 1'b0;
          state_d = SOut;
        end else if ((idx_q + 1'b1) < count_q) begin
          idx_d   = idx_q + 1'b1;
          rd_en   = 1'b1;
          rd_addr = idx_d[AddrW-1:0];
          state_d = SGeo;
        end else begin
          state_d = SOut;
        end
      end
      SOut: begin
        valid_d = 1'b1;
        okeep_d = keep_q;
        ofull_d = keep_q && full;
        oend_d  = last_q;
        if (keep_q && !full) begin
          wr_en   = 1'b1;
          count_d = count_q + 1'b1;
        end
        if (last_q) begin
          count_d = '0;
        end
        state_d = SIdle;
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      count_q <= '0;
      valid_q <= 1'b0;
      num_q   <= NumReset;
      den_q   <= DenReset;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      valid_q <= valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          CfgNum:  num_q <= cfg_data_i;
          CfgDen:  den_q <= cfg_data_i;
          default: num_q <= num_q;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cur_q.x <= box_x_i;
      cur_q.y <= box_y_i;
      cur_q.w <= box_w_i;
      cur_q.h <= box_h_i;
      last_q  <= frame_last_i;
    end
    idx_q     <= idx_d;
    keep_q    <= keep_d;
    areaa_q   <= areaa_d;
    inter_q   <= inter_d;
    areab_q   <= areab_d;
    uni_q     <= uni_d;
    inw_q     <= inw_d;
    inh_q     <= inh_d;
    bw_q      <= bw_d;
    bh_q      <= bh_d;
    contain_q <= contain_d;
    okeep_q   <= okeep_d;
    ofull_q   <= ofull_d;
    oend_q    <= oend_d;
  end

  assign valid_o      = valid_q;
  assign keep_o       = okeep_q;
  assign table_full_o = ofull_q;
  assign frame_end_o  = oend_q;

  a_full_implies_keep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && table_full_o) |-> keep_o)
    else $error("table_full without keep");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(KeepMax))
    else $error("kept count above table size");

  a_result_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (state_q == SIdle))
    else $error("result strobe while busy");

  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy)
    else $error("accepted item did not raise busy");

  a_frame_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && frame_end_o) |-> (count_q == '0))
    else $error("table not cleared at frame end");

endmodule

@@ test/box_overlap_dedup_unit_tb.sv @@
// Self-checking testbench for box_overlap_dedup_unit: IoU dedup predictor, random frames.
`timescale 1ns / 100ps

module box_overlap_dedup_unit_tb
  import bod_pkg::*;
();

  localparam int CycLimit   = 4_000_000;
  localparam int IdlePad    = 16;
  localparam int PhaseItems = 250;

  typedef struct packed {
    box_t box;
    logic last;
  } det_t;

  typedef struct packed {
    logic keep;
    logic full;
    logic fend;
  } verdict_t;

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  logic [15:0] box_x_i;
  logic [15:0] box_y_i;
  logic [15:0] box_w_i;
  logic [15:0] box_h_i;
  logic        frame_last_i;
  logic        valid_o;
  logic        keep_o;
  logic        table_full_o;
  logic        frame_end_o;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic        cfg_index_i;
  logic [3:0]  cfg_data_i;

  box_overlap_dedup_unit dut (.*);

  det_t     det_q[$];
  verdict_t verdict_q[$];

  box_t       kept_tbl [KeepMax];
  int         kept_cnt = 0;
  logic [3:0] thr_num = NumReset;
  logic [3:0] thr_den = DenReset;

  int   fail_cnt    = 0;
  int   cyc_cnt     = 0;
  int   sent_cnt    = 0;
  int   phase_items = 0;
  int   burst_left  = 8;
  int   gap_left    = 0;
  bit   taken       = 1'b0;
  bit   drain_hold  = 1'b0;
  det_t cur;
  verdict_t want, got;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cyc_cnt++;
    if (cyc_cnt > CycLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // duplicate test of box a against kept box b
  function automatic bit is_redundant(box_t a, box_t b);
    longint unsigned lx, ty, rx, by, ra, rb, ba, bb;
    longint unsigned iw, ih, inter, uni, aa, ab, num, den;
    box_t isect;
    lx = (a.x > b.x) ? a.x : b.x;
    ty = (a.y > b.y) ? a.y : b.y;
    ra = a.x;
    ra += a.w;
    rb = b.x;
    rb += b.w;
    ba = a.y;
    ba += a.h;
    bb = b.y;
    bb += b.h;
    rx = (ra < rb) ? ra : rb;
    by = (ba < bb) ? ba : bb;
    if (rx <= lx || by <= ty) begin
      isect = '0;
    end else begin
      isect.x = lx[15:0];
      isect.y = ty[15:0];
      isect.w = 16'(rx - lx);
      isect.h = 16'(by - ty);
    end
    if (isect == a || isect == b) return 1'b1;
    iw = isect.w;
    ih = isect.h;
    inter = iw * ih;
    aa = a.w;
    aa = aa * a.h;
    ab = b.w;
    ab = ab * b.h;
    uni = aa + ab - inter;
    num = thr_num;
    den = thr_den;
    if (uni == 0 || den == 0) return 1'b0;
    return (inter * den) > (num * uni);
  endfunction

  function automatic verdict_t nms_predict(box_t b, logic last);
    verdict_t v;
    v.keep = 1'b1;
    v.full = 1'b0;
    v.fend = last;
    for (int i = 0; i < kept_cnt; i++) begin
      if (is_redundant(b, kept_tbl[i])) begin
        v.keep = 1'b0;
        break;
      end
    end
    if (v.keep) begin
      if (kept_cnt < KeepMax) begin
        kept_tbl[kept_cnt] = b;
        kept_cnt++;
      end else begin
        v.full = 1'b1;
      end
    end
    if (last) kept_cnt = 0;
    return v;
  endfunction

  // driver
  always @(negedge clk_i) begin
    if (rst_ni && (taken || !start)) begin
      taken = 1'b0;
      if (drain_hold && verdict_q.size() == 0) drain_hold = 1'b0;
      if (gap_left != 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (drain_hold || det_q.size() == 0) begin
        start <= 1'b0;
      end else begin
        cur = det_q.pop_front();
        box_x_i      <= cur.box.x;
        box_y_i      <= cur.box.y;
        box_w_i      <= cur.box.w;
        box_h_i      <= cur.box.h;
        frame_last_i <= cur.last;
        start        <= 1'b1;
        sent_cnt++;
        if (sent_cnt % 300 == 150) drain_hold = 1'b1;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 24);
          gap_left   = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 40)
                                                   : $urandom_range(0, 5);
        end else begin
          burst_left--;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (valid_o) begin
        if (verdict_q.size() == 0) begin
          $error("result strobe with no item outstanding");
          fail_cnt++;
        end else begin
          want = verdict_q.pop_front();
          got  = '{keep: keep_o, full: table_full_o, fend: frame_end_o};
          if (got.keep !== want.keep) begin
            $error("keep: expected %0b, got %0b", want.keep, got.keep);
            fail_cnt++;
          end
          if (got.full !== want.full) begin
            $error("table_full: expected %0b, got %0b", want.full, got.full);
            fail_cnt++;
          end
          if (got.fend !== want.fend) begin
            $error("frame_end: expected %0b, got %0b", want.fend, got.fend);
            fail_cnt++;
          end
        end
      end
      if (start && !busy) begin
        verdict_q.insert(verdict_q.size(),
                         nms_predict({box_h_i, box_w_i, box_y_i, box_x_i}, frame_last_i));
        taken = 1'b1;
      end
    end
  end

  task automatic push_xywh(logic [15:0] x, logic [15:0] y, logic [15:0] w,
                           logic [15:0] h, logic last);
    det_t d;
    d.box.x = x;
    d.box.y = y;
    d.box.w = w;
    d.box.h = h;
    d.last  = last;
    det_q.insert(det_q.size(), d);
    phase_items++;
  endtask

  task automatic gen_frame(int n);
    box_t        prior[$];
    box_t        p, b;
    logic [15:0] cx, cy;
    int          sel;
    cx = 16'($urandom);
    cy = 16'($urandom);
    for (int k = 0; k < n; k++) begin
      sel = $urandom_range(0, 9);
      if (sel == 0) begin
        b.x = 16'($urandom);
        b.y = 16'($urandom);
        b.w = 16'($urandom);
        b.h = 16'($urandom);
      end else if (sel <= 5 && prior.size() != 0) begin
        p = prior[$urandom_range(0, prior.size() - 1)];
        case ($urandom_range(0, 3))
          0: b = p;
          1: begin
            b.x = p.x + 16'($urandom_range(0, 8)) - 16'd4;
            b.y = p.y + 16'($urandom_range(0, 8)) - 16'd4;
            b.w = p.w + 16'($urandom_range(0, 8)) - 16'd4;
            b.h = p.h + 16'($urandom_range(0, 8)) - 16'd4;
          end
          2: begin
            b.x = p.x + 16'($urandom_range(0, p.w));
            b.y = p.y + 16'($urandom_range(0, p.h));
            b.w = 16'($urandom_range(0, p.w));
            b.h = 16'($urandom_range(0, p.h));
          end
          default: begin
            b   = p;
            b.x = p.x + p.w / 4;
            b.h = p.h + p.h / 8;
          end
        endcase
      end else begin
        b.x = cx + 16'($urandom_range(0, 200));
        b.y = cy + 16'($urandom_range(0, 200));
        b.w = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 3))
                                          : 16'($urandom_range(4, 90));
        b.h = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 3))
                                          : 16'($urandom_range(4, 90));
      end
      prior.insert(prior.size(), b);
      push_xywh(b.x, b.y, b.w, b.h, k == n - 1);
    end
  endtask

  // disjoint grid overflows the table, with copies mixed in
  task automatic gen_full_frame();
    box_t cells[$];
    box_t b;
    int   n_new, total_new;
    total_new = KeepMax + $urandom_range(2, 8);
    n_new     = 0;
    while (n_new < total_new) begin
      if (cells.size() != 0 && $urandom_range(0, 4) == 0) begin
        b = cells[$urandom_range(0, cells.size() - 1)];
      end else begin
        b.x = 16'((n_new % 16) * 64 + $urandom_range(0, 8));
        b.y = 16'((n_new / 16) * 64 + $urandom_range(0, 8));
        b.w = 16'($urandom_range(1, 40));
        b.h = 16'($urandom_range(1, 40));
        cells.insert(cells.size(), b);
        n_new++;
      end
      push_xywh(b.x, b.y, b.w, b.h, n_new == total_new);
    end
  endtask

  task automatic wait_idle();
    while (det_q.size() != 0 || start || busy || verdict_q.size() != 0) @(posedge clk_i);
    repeat (IdlePad) @(posedge clk_i);
  endtask

  task automatic cfg_write(logic idx, logic [3:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    if (idx == CfgNum) thr_num = data;
    else thr_den = data;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic run_phase(logic [3:0] num, logic [3:0] den, bit with_full);
    cfg_write(CfgNum, num);
    cfg_write(CfgDen, den);
    phase_items = 0;
    if (with_full) gen_full_frame();
    while (phase_items < PhaseItems) begin
      if ($urandom_range(0, 7) == 0) gen_frame($urandom_range(13, 40));
      else gen_frame($urandom_range(1, 12));
    end
    wait_idle();
  endtask

  initial begin
    rst_ni       = 1'b0;
    start        = 1'b0;
    box_x_i      = '0;
    box_y_i      = '0;
    box_w_i      = '0;
    box_h_i      = '0;
    frame_last_i = 1'b0;
    cfg_valid_i  = 1'b0;
    cfg_index_i  = CfgNum;
    cfg_data_i   = '0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // zero box in the table swallows the rest of its frame
    push_xywh(16'd0, 16'd0, 16'd0, 16'd0, 1'b0);
    push_xywh(16'd0, 16'd0, 16'd0, 16'd0, 1'b0);
    push_xywh(16'd100, 16'd100, 16'd50, 16'd50, 1'b1);
    // identical, contained, containing, high and low IoU, edge touch, zero area
    push_xywh(16'd100, 16'd100, 16'd50, 16'd50, 1'b0);
    push_xywh(16'd100, 16'd100, 16'd50, 16'd50, 1'b0);
    push_xywh(16'd110, 16'd110, 16'd10, 16'd10, 1'b0);
    push_xywh(16'd90, 16'd90, 16'd70, 16'd70, 1'b0);
    push_xywh(16'd105, 16'd100, 16'd50, 16'd50, 1'b0);
    push_xywh(16'd130, 16'd100, 16'd50, 16'd50, 1'b0);
    push_xywh(16'd200, 16'd200, 16'd10, 16'd10, 1'b0);
    push_xywh(16'd210, 16'd200, 16'd10, 16'd10, 1'b0);
    push_xywh(16'd5, 16'd5, 16'd0, 16'd0, 1'b0);
    push_xywh(16'd7, 16'd7, 16'd0, 16'd0, 1'b0);
    push_xywh(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
    push_xywh(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
    push_xywh(16'd0, 16'd0, 16'hFFFF, 16'hFFFF, 1'b1);
    push_xywh(16'hFFFF, 16'd0, 16'd0, 16'hFFFF, 1'b1);
    push_xywh(16'd0, 16'd0, 16'd1, 16'd1, 1'b0);
    push_xywh(16'd0, 16'd0, 16'd1, 16'd1, 1'b1);
    // table was cleared by the previous frame end
    push_xywh(16'd100, 16'd100, 16'd50, 16'd50, 1'b1);
    wait_idle();

    run_phase(4'd0, 4'd1, 1'b1);
    run_phase(4'd15, 4'd1, 1'b0);
    run_phase(4'd1, 4'd2, 1'b1);
    run_phase(4'd7, 4'd0, 1'b0);
    run_phase(4'd15, 4'd15, 1'b1);
    run_phase(4'd3, 4'd4, 1'b0);
    run_phase(4'd7, 4'd10, 1'b1);

    if (fail_cnt == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/bod_pkg.sv
rtl/bod_ram.sv
rtl/box_overlap_dedup_unit.sv
test/box_overlap_dedup_unit_tb.sv
